@@ rtl/rcsfd_pkg.sv @@
// Shared types and constants for the serial frame decoder.
package rcsfd_pkg;

   localparam int OVERHEAD  = 3;
   localparam int CHANNELS  = 14;
   localparam int CHAN_W    = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_GAP_MS       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COMMAND_CODE = 2'd2;

   localparam logic [7:0]  GAP_MS_RST       = 8'd3;
   localparam logic [5:0]  MAX_LENGTH_RST   = 6'd32;
   localparam logic [7:0]  COMMAND_CODE_RST = 8'd64;
   localparam logic [7:0]  IDLE_MAX         = 8'hFF;
   localparam logic [15:0] SUM_INIT         = 16'hFFFF;

   typedef enum logic [4:0] {
      F_LENGTH   = 5'b00001,
      F_DATA     = 5'b00010,
      F_CHK_LOW  = 5'b00100,
      F_CHK_HIGH = 5'b01000,
      F_DISCARD  = 5'b10000
   } frame_state_type;

   typedef enum logic [3:0] {
      E_IDLE = 4'b0001,
      E_LO   = 4'b0010,
      E_HI   = 4'b0100,
      E_PUT  = 4'b1000
   } emit_state_type;

endpackage

@@ rtl/rcsfd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rcsfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data between reads
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/rc_serial_frame_decoder_unit.sv @@
// Serial radio-control frame decoder: framing, checksum and channel readout.
//
//   channel  direction  payload
//   req_     in         tuser[0] kind, tdata[7:0] rx_byte
//   rsp_     out        tdata[3:0] channel_index, tdata[19:4] channel_value, tlast
//   csr_     in         csr_index selects register, csr_data holds the value
//
// A tick or byte is taken whenever no channel readout is running. A frame that
// passes its checksum and command match blocks input while the channels are read
// from the frame RAM, each in E_LO, E_HI, E_PUT (two reads on its single read port),
// for fourteen channels; E_PUT waits while the rsp_ side stalls. Reset is synchronous;
// the frame RAM reads as zero through per-entry valid bits until written.
module rc_serial_frame_decoder_unit #(
   parameter int STORE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [0:0]  req_tuser,   // [0] kind

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [3:0] channel_index, [19:4] channel_value, [23:20] zero
   output logic        rsp_tlast,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [rcsfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]  csr_data
);

   localparam int IDX_W = $clog2(STORE_DEPTH);

   // configuration
   logic [7:0] gap_ms_ff;
   logic [5:0] max_length_ff;
   logic [7:0] command_code_ff;

   // parser state
   rcsfd_pkg::frame_state_type frame_ff, frame_in, frame_cur;
   logic [7:0]       idle_ff, idle_in;
   logic [IDX_W-1:0] byte_idx_ff, byte_idx_in;
   logic [IDX_W-1:0] data_len_ff, data_len_in;
   logic [15:0]      sum_ff, sum_in;
   logic [7:0]       check_low_ff, check_low_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [STORE_DEPTH-1:0] valid_ff, valid_in;

   // emitter state
   rcsfd_pkg::emit_state_type emit_ff, emit_in;
   logic [rcsfd_pkg::CHAN_W-1:0] chan_ff, chan_in;
   logic [7:0]  lo_ff, lo_in;
   logic        rd_valid_ff, rd_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;

   // RAM ports
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [7:0]       rd_data;
   logic [7:0]       rd_masked;

   logic             accept;
   logic             is_byte;
   logic [7:0]       rx;
   logic [7:0]       limit;
   logic [IDX_W-1:0] byte_idx_inc;
   logic [IDX_W-1:0] addr_lo;
   logic [IDX_W-1:0] addr_hi;
   logic             last_chan;

   rcsfd_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (rx),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (emit_ff == rcsfd_pkg::E_IDLE);
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;
   assign is_byte    = req_tuser[0];
   assign rx         = req_tdata;

   assign limit = (8'(max_length_ff) > 8'(STORE_DEPTH)) ? 8'(STORE_DEPTH)
                                                        : 8'(max_length_ff);
   assign byte_idx_inc = byte_idx_ff + 1'b1;

   // channel i sits at bytes 2i+1 and 2i+2
   assign addr_lo   = IDX_W'({chan_ff, 1'b1});
   assign addr_hi   = IDX_W'(5'({chan_ff, 1'b0}) + 5'd2);
   assign last_chan = (chan_ff == rcsfd_pkg::CHAN_W'(rcsfd_pkg::CHANNELS - 1));
   assign rd_masked = rd_valid_ff ? rd_data : 8'd0;

   // a byte after a long enough gap restarts framing
   assign frame_cur = (idle_ff >= gap_ms_ff) ? rcsfd_pkg::F_LENGTH : frame_ff;

   always_comb begin
      frame_in     = frame_ff;
      idle_in      = idle_ff;
      byte_idx_in  = byte_idx_ff;
      data_len_in  = data_len_ff;
      sum_in       = sum_ff;
      check_low_in = check_low_ff;
      cmd_in       = cmd_ff;
      valid_in     = valid_ff;
      emit_in      = emit_ff;
      chan_in      = chan_ff;
      lo_in        = lo_ff;
      rd_valid_in  = rd_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = byte_idx_ff;
      rd_en        = 1'b0;
      rd_addr      = addr_lo;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept && !is_byte) begin
         if (idle_ff != rcsfd_pkg::IDLE_MAX) begin
            idle_in = idle_ff + 1'b1;
         end
      end else if (accept) begin
         idle_in = 8'd0;
         case (frame_cur)
            rcsfd_pkg::F_LENGTH: begin
               if (rx <= limit && rx > 8'(rcsfd_pkg::OVERHEAD)) begin
                  byte_idx_in = '0;
                  data_len_in = IDX_W'(rx - 8'(rcsfd_pkg::OVERHEAD));
                  sum_in      = rcsfd_pkg::SUM_INIT - 16'(rx);
                  frame_in    = rcsfd_pkg::F_DATA;
               end else begin
                  frame_in = rcsfd_pkg::F_DISCARD;
               end
            end
            rcsfd_pkg::F_DATA: begin
               wr_en                = 1'b1;
               valid_in[byte_idx_ff] = 1'b1;
               if (byte_idx_ff == '0) begin
                  cmd_in = rx;
               end
               byte_idx_in = byte_idx_inc;
               sum_in      = sum_ff - 16'(rx);
               frame_in    = (byte_idx_inc >= data_len_ff) ? rcsfd_pkg::F_CHK_LOW
                                                           : rcsfd_pkg::F_DATA;
            end
            rcsfd_pkg::F_CHK_LOW: begin
               check_low_in = rx;
               frame_in     = rcsfd_pkg::F_CHK_HIGH;
            end
            rcsfd_pkg::F_CHK_HIGH: begin
               if (sum_ff == {rx, check_low_ff} && cmd_ff == command_code_ff) begin
                  chan_in = '0;
                  emit_in = rcsfd_pkg::E_LO;
               end
               frame_in = rcsfd_pkg::F_DISCARD;
            end
            default: begin
               frame_in = rcsfd_pkg::F_DISCARD;
            end
         endcase
      end

      case (emit_ff)
         rcsfd_pkg::E_IDLE: begin
         end
         rcsfd_pkg::E_LO: begin
            rd_en       = 1'b1;
            rd_addr     = addr_lo;
            rd_valid_in = valid_ff[addr_lo];
            emit_in     = rcsfd_pkg::E_HI;
         end
         rcsfd_pkg::E_HI: begin
            lo_in       = rd_masked;
            rd_en       = 1'b1;
            rd_addr     = addr_hi;
            rd_valid_in = valid_ff[addr_hi];
            emit_in     = rcsfd_pkg::E_PUT;
         end
         rcsfd_pkg::E_PUT: begin
            // load the output slot once it is free or being drained
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, rd_masked, lo_ff, chan_ff};
               rsp_last_in  = last_chan;
               if (last_chan) begin
                  emit_in = rcsfd_pkg::E_IDLE;
               end else begin
                  chan_in = chan_ff + 1'b1;
                  emit_in = rcsfd_pkg::E_LO;
               end
            end
         end
         default: begin
            emit_in = rcsfd_pkg::E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ms_ff       <= rcsfd_pkg::GAP_MS_RST;
         max_length_ff   <= rcsfd_pkg::MAX_LENGTH_RST;
         command_code_ff <= rcsfd_pkg::COMMAND_CODE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rcsfd_pkg::CSR_GAP_MS:       gap_ms_ff       <= csr_data;
            rcsfd_pkg::CSR_MAX_LENGTH:   max_length_ff   <= csr_data[5:0];
            rcsfd_pkg::CSR_COMMAND_CODE: command_code_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff     <= rcsfd_pkg::F_DISCARD;
         idle_ff      <= rcsfd_pkg::IDLE_MAX;
         byte_idx_ff  <= '0;
         data_len_ff  <= '0;
         sum_ff       <= '0;
         check_low_ff <= '0;
         cmd_ff       <= '0;
         valid_ff     <= '0;
         emit_ff      <= rcsfd_pkg::E_IDLE;
         chan_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         frame_ff     <= frame_in;
         idle_ff      <= idle_in;
         byte_idx_ff  <= byte_idx_in;
         data_len_ff  <= data_len_in;
         sum_ff       <= sum_in;
         check_low_ff <= check_low_in;
         cmd_ff       <= cmd_in;
         valid_ff     <= valid_in;
         emit_ff      <= emit_in;
         chan_ff      <= chan_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_emit_starts_on_trailer : assert property (@(posedge clock) disable iff (reset)
      (emit_ff == rcsfd_pkg::E_IDLE && emit_in == rcsfd_pkg::E_LO) |->
         (accept && is_byte && frame_cur == rcsfd_pkg::F_CHK_HIGH))
      else $error("channel readout started without a checksum trailer");

   a_index_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3:0] < rcsfd_pkg::CHAN_W'(rcsfd_pkg::CHANNELS)))
      else $error("channel index out of range");

   a_last_on_final : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (rsp_tlast == (rsp_tdata[3:0] == rcsfd_pkg::CHAN_W'(rcsfd_pkg::CHANNELS - 1))))
      else $error("last flag not on final channel");

   a_idle_after_last : assert property (@(posedge clock) disable iff (reset)
      (emit_ff == rcsfd_pkg::E_PUT && emit_in == rcsfd_pkg::E_IDLE) |=>
         (rsp_tvalid && rsp_tlast))
      else $error("readout ended without the final channel in the output slot");

   a_index_in_store : assert property (@(posedge clock) disable iff (reset)
      (frame_ff == rcsfd_pkg::F_DATA) |->
         (32'(byte_idx_ff) < STORE_DEPTH && byte_idx_ff < data_len_ff))
      else $error("data byte index beyond frame");

endmodule

@@ test/tb_rc_serial_frame_decoder_unit.sv @@
// Self-checking testbench for the serial frame decoder: framing, checksum and channel readout.
module tb_rc_serial_frame_decoder_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam bit KIND_TICK        = 1'b0;
   localparam bit KIND_BYTE        = 1'b1;
   localparam int STORE_SLOTS      = 32;
   localparam int SETTLE_CYCLES    = 60;
   localparam int SETTLE_LIMIT     = 20000;
   localparam int RUN_LIMIT_NS     = 4000000;

   typedef enum int {
      FR_GOOD,
      FR_BAD_SUM,
      FR_OTHER_CMD,
      FR_TOO_LONG,
      FR_NO_DATA,
      FR_CUT
   } frame_kind_type;

   typedef struct packed {
      logic [rcsfd_pkg::CHAN_W-1:0] chan;
      logic [15:0]                  word;
      logic                         last;
   } chan_word_type;

   typedef logic [7:0] octet_q_type[$];

   // Frame parser mirror plus the queue of channel words it predicts.
   class channel_scoreboard;
      logic [7:0]                 gap_ms;
      logic [5:0]                 max_len;
      logic [7:0]                 cmd;
      rcsfd_pkg::frame_state_type fstate;
      logic [7:0]                 idle_ms;
      int                         byte_idx;
      int                         data_len;
      logic [15:0]                run_sum;
      logic [7:0]                 chk_lo;
      logic [7:0]                 store [STORE_SLOTS];
      chan_word_type              expected_q[$];
      int                         errors;

      function new();
         gap_ms   = rcsfd_pkg::GAP_MS_RST;
         max_len  = rcsfd_pkg::MAX_LENGTH_RST;
         cmd      = rcsfd_pkg::COMMAND_CODE_RST;
         fstate   = rcsfd_pkg::F_DISCARD;
         idle_ms  = rcsfd_pkg::IDLE_MAX;
         byte_idx = 0;
         data_len = 0;
         run_sum  = '0;
         chk_lo   = '0;
         foreach (store[i]) store[i] = '0;
         errors   = 0;
      endfunction

      function void set_reg(logic [rcsfd_pkg::CSR_IDX_W-1:0] idx, logic [7:0] data);
         case (idx)
            rcsfd_pkg::CSR_GAP_MS: begin
               gap_ms = data;
            end
            rcsfd_pkg::CSR_MAX_LENGTH: begin
               max_len = data[5:0];
            end
            rcsfd_pkg::CSR_COMMAND_CODE: begin
               cmd = data;
            end
            default: begin
            end
         endcase
      endfunction

      function void note_item(bit kind, logic [7:0] b);
         int            lim;
         chan_word_type w;
         if (kind == KIND_TICK) begin
            if (idle_ms != rcsfd_pkg::IDLE_MAX) idle_ms++;
            return;
         end
         if (idle_ms >= gap_ms) fstate = rcsfd_pkg::F_LENGTH;
         idle_ms = '0;
         case (fstate)
            rcsfd_pkg::F_LENGTH: begin
               lim = (max_len > STORE_SLOTS) ? STORE_SLOTS : int'(max_len);
               if (int'(b) <= lim && int'(b) > rcsfd_pkg::OVERHEAD) begin
                  byte_idx = 0;
                  data_len = int'(b) - rcsfd_pkg::OVERHEAD;
                  run_sum  = rcsfd_pkg::SUM_INIT - b;
                  fstate   = rcsfd_pkg::F_DATA;
               end else begin
                  fstate = rcsfd_pkg::F_DISCARD;
               end
            end
            rcsfd_pkg::F_DATA: begin
               if (byte_idx < STORE_SLOTS) store[byte_idx] = b;
               byte_idx++;
               run_sum = run_sum - b;
               if (byte_idx >= data_len) fstate = rcsfd_pkg::F_CHK_LOW;
            end
            rcsfd_pkg::F_CHK_LOW: begin
               chk_lo = b;
               fstate = rcsfd_pkg::F_CHK_HIGH;
            end
            rcsfd_pkg::F_CHK_HIGH: begin
               if (run_sum == {b, chk_lo} && store[0] == cmd) begin
                  for (int i = 0; i < rcsfd_pkg::CHANNELS; i++) begin
                     w.chan = i[rcsfd_pkg::CHAN_W-1:0];
                     w.word = {store[2*i+2], store[2*i+1]};
                     w.last = (i == rcsfd_pkg::CHANNELS - 1);
                     expected_q.push_back(w);
                  end
               end
               fstate = rcsfd_pkg::F_DISCARD;
            end
            default: begin
               fstate = rcsfd_pkg::F_DISCARD;
            end
         endcase
      endfunction

      function void check_word(logic [rcsfd_pkg::CHAN_W-1:0] chan, logic [15:0] word,
                               logic last);
         chan_word_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected channel word: expected none, actual chan %0d value %h last %b",
                     $time, chan, word, last);
            return;
         end
         want = expected_q.pop_front();
         if (want.chan !== chan) begin
            errors++;
            $display("%0t: channel_index mismatch: expected %0d, actual %0d",
                     $time, want.chan, chan);
         end
         if (want.word !== word) begin
            errors++;
            $display("%0t: channel_value mismatch on chan %0d: expected %h, actual %h",
                     $time, want.chan, want.word, word);
         end
         if (want.last !== last) begin
            errors++;
            $display("%0t: last_channel mismatch on chan %0d: expected %b, actual %b",
                     $time, want.chan, want.last, last);
         end
      endfunction
   endclass

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata  = '0;
   logic [0:0]                      req_tuser  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [23:0]                     rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [rcsfd_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [7:0]                      csr_data   = '0;

   channel_scoreboard sb;
   bit                calm       = 1'b0;
   int                byte_count = 0;

   rc_serial_frame_decoder_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Result side: check each transfer, stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_word(rsp_tdata[3:0], rsp_tdata[19:4], rsp_tlast);
      rsp_tready <= calm || ($urandom_range(99) >= 18);
   end

   function automatic logic [7:0] random_octet();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   task automatic send_item(bit kind, logic [7:0] value);
      int hold = 0;
      while (!calm && $urandom_range(99) < 18) hold++;
      if (hold > 0) begin
         req_tvalid <= 1'b0;
         repeat (hold) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      sb.note_item(kind, value);
      if (kind == KIND_BYTE) byte_count++;
   endtask

   task automatic send_ticks(int n);
      repeat (n) send_item(KIND_TICK, 8'($urandom_range(255)));
   endtask

   // Occasionally slip in ticks shorter than the gap, so framing must hold.
   task automatic send_byte(logic [7:0] value);
      int most;
      if (sb.gap_ms >= 2 && $urandom_range(5) == 0) begin
         most = (sb.gap_ms - 1 > 4) ? 4 : sb.gap_ms - 1;
         send_ticks($urandom_range(1, most));
      end
      send_item(KIND_BYTE, value);
   endtask

   task automatic send_frame(octet_q_type body, bit bad_sum);
      logic [15:0] csum;
      csum = rcsfd_pkg::SUM_INIT;
      foreach (body[i]) begin
         csum = csum - body[i];
         send_byte(body[i]);
      end
      if (bad_sum) csum = csum ^ (16'h1 << $urandom_range(15));
      send_byte(csum[7:0]);
      send_byte(csum[15:8]);
   endtask

   task automatic send_noise();
      repeat ($urandom_range(3)) send_byte(random_octet());
   endtask

   task automatic random_frame();
      octet_q_type    body;
      int             lead;
      int             lim;
      int             len;
      int             pick;
      frame_kind_type fk;
      lead = sb.gap_ms;
      if (lead > 0 && $urandom_range(9) == 0) lead--;
      send_ticks(lead);
      lim  = (sb.max_len > STORE_SLOTS) ? STORE_SLOTS : int'(sb.max_len);
      pick = $urandom_range(99);
      if (pick < 70)      fk = FR_GOOD;
      else if (pick < 78) fk = FR_BAD_SUM;
      else if (pick < 84) fk = FR_OTHER_CMD;
      else if (pick < 90) fk = FR_TOO_LONG;
      else if (pick < 95) fk = FR_NO_DATA;
      else                fk = FR_CUT;
      case (fk)
         FR_TOO_LONG: begin
            send_byte(8'($urandom_range(lim + 1, 255)));
            send_noise();
         end
         FR_NO_DATA: begin
            send_byte(8'($urandom_range(rcsfd_pkg::OVERHEAD)));
            send_noise();
         end
         default: begin
            if (lim <= rcsfd_pkg::OVERHEAD)
               len = $urandom_range(rcsfd_pkg::OVERHEAD + 1, STORE_SLOTS);
            else if ($urandom_range(3) == 0)
               len = lim;
            else
               len = $urandom_range(rcsfd_pkg::OVERHEAD + 1, lim);
            body.push_back(8'(len));
            if (fk == FR_OTHER_CMD)
               body.push_back(sb.cmd ^ 8'($urandom_range(1, 255)));
            else
               body.push_back(sb.cmd);
            repeat (len - rcsfd_pkg::OVERHEAD - 1) body.push_back(random_octet());
            if (fk == FR_CUT) begin
               // Drop the tail; the next gap restarts framing.
               repeat ($urandom_range(1, body.size())) send_byte(body.pop_front());
            end else begin
               send_frame(body, fk == FR_BAD_SUM);
            end
         end
      endcase
   endtask

   task automatic run_frames_for(int bytes);
      int start;
      start = byte_count;
      while (byte_count - start < bytes) random_frame();
   endtask

   task automatic write_settings(logic [7:0] gap, logic [7:0] len_max, logic [7:0] code);
      logic [rcsfd_pkg::CSR_IDX_W-1:0] idxs [3];
      logic [7:0]                      vals [3];
      idxs = '{rcsfd_pkg::CSR_GAP_MS, rcsfd_pkg::CSR_MAX_LENGTH,
               rcsfd_pkg::CSR_COMMAND_CODE};
      vals = '{gap, len_max, code};
      csr_valid <= 1'b1;
      for (int k = 0; k < 3; k++) begin
         csr_index <= idxs[k];
         csr_data  <= vals[k];
         do @(posedge clock); while (!csr_ready);
         sb.set_reg(idxs[k], vals[k]);
      end
      csr_valid <= 1'b0;
   endtask

   // Drop valid, wait out every expected channel word, then the readout tail.
   task automatic settle();
      req_tvalid <= 1'b0;
      for (int n = 0; n < SETTLE_LIMIT && sb.expected_q.size() != 0; n++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic directed_frames();
      octet_q_type f;
      // Full channel readout from a nearly empty store, with extreme data bytes.
      f = '{8'd6, rcsfd_pkg::COMMAND_CODE_RST, 8'hFF, 8'hFF};
      send_frame(f, 1'b0);
      // Length one past the store, then a length with no data bytes.
      send_ticks(sb.gap_ms);
      send_item(KIND_BYTE, 8'(STORE_SLOTS + 1));
      send_ticks(sb.gap_ms);
      send_item(KIND_BYTE, 8'(rcsfd_pkg::OVERHEAD));
      // Shortest frame with a broken trailer, then with another command.
      send_ticks(sb.gap_ms);
      f = '{8'd4, rcsfd_pkg::COMMAND_CODE_RST};
      send_frame(f, 1'b1);
      send_ticks(sb.gap_ms);
      f = '{8'd4, rcsfd_pkg::COMMAND_CODE_RST + 8'd1};
      send_frame(f, 1'b0);
   endtask

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_frames();
      run_frames_for(20);
      settle();

      // Every byte restarts framing; a length limit above the store is clipped to it.
      write_settings(8'd0, 8'd63, 8'd0);
      run_frames_for(20);
      settle();

      // Long gap, shortest frames.
      write_settings(8'd9, 8'd4, 8'd255);
      repeat (3) random_frame();
      settle();

      write_settings(8'd1, 8'd17, 8'($urandom_range(255)));
      run_frames_for(25);
      settle();

      // No idling on either side.
      calm = 1'b1;
      write_settings(8'($urandom_range(2, 6)), 8'd32, 8'($urandom_range(255)));
      run_frames_for(35);
      settle();
      calm = 1'b0;

      // No length passes.
      write_settings(8'd3, 8'd0, rcsfd_pkg::COMMAND_CODE_RST);
      run_frames_for(10);
      settle();

      write_settings(8'($urandom_range(1, 8)), 8'($urandom_range(4, 32)),
                     8'($urandom_range(255)));
      run_frames_for(30);
      settle();

      if (sb.expected_q.size() != 0) begin
         sb.errors++;
         $display("%0t: channel words missing: expected %0d more, actual 0",
                  $time, sb.expected_q.size());
      end
      if (sb.errors == 0)
         $display("tb_rc_serial_frame_decoder_unit: done, clean");
      else
         $display("tb_rc_serial_frame_decoder_unit: done, errors");
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("%0t: timeout", $time);
      $display("tb_rc_serial_frame_decoder_unit: done, errors");
      $finish;
   end

endmodule
